/* design/mat4_transform_accumulator_top_defines.svh */
// Assertion macros for the transform accumulator
`ifndef MAT4_TRANSFORM_ACCUMULATOR_TOP_DEFINES_SVH
`define MAT4_TRANSFORM_ACCUMULATOR_TOP_DEFINES_SVH
// implication checked on every clock edge outside reset
`define MTA_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("mta check failed");
// next-cycle implication checked outside reset
`define MTA_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("mta check failed");
`endif

/* design/mta_pkg.sv */
// ----------------------------------------------------------------------------
// mta_pkg
// Types, codes and constants of the 4x4 transform accumulator.
// ----------------------------------------------------------------------------
`default_nettype none
package mta_pkg;

    localparam int FRAC_BITS    = 16;
    localparam int CORDIC_STEPS = 16;
    localparam int ANG_FRAC     = 24;
    localparam int CORD_FRAC    = 30;
    localparam int TABLE_LEN    = 24;
    localparam int RED_STEPS    = (FRAC_BITS < 23) ? 24 - FRAC_BITS : 1;

    localparam logic signed [33:0] CORD_GAIN   = 34'sd652032874;
    localparam logic signed [31:0] ONE_Q       = 32'sd1 <<< FRAC_BITS;
    localparam logic signed [33:0] HALF_TURN   = 34'sd180 <<< FRAC_BITS;
    localparam logic signed [33:0] QUARTER     = 34'sd90 <<< FRAC_BITS;
    localparam logic signed [33:0] FULL_TURN   = 34'sd360 <<< FRAC_BITS;
    localparam logic signed [33:0] TURN_OFFSET = FULL_TURN <<< (RED_STEPS - 1);

    typedef enum logic [3:0] {
        REQ_IDENTITY = 4'd0,
        REQ_SCALE    = 4'd1,
        REQ_TRANS    = 4'd2,
        REQ_ROT_X    = 4'd3,
        REQ_ROT_Y    = 4'd4,
        REQ_ROT_Z    = 4'd5,
        REQ_STAGE    = 4'd6,
        REQ_MUL      = 4'd7,
        REQ_READ     = 4'd8
    } req_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_REDUCE,
        ST_FOLD,
        ST_CORDIC,
        ST_TRIG,
        ST_MAC,
        ST_COPY,
        ST_READ
    } state_t;

    typedef struct packed {
        logic [3:0]         req_type;
        logic signed [31:0] arg_x;
        logic signed [31:0] arg_y;
        logic signed [31:0] arg_z;
        logic signed [31:0] angle;
        logic [3:0]         element_index;
        logic signed [31:0] element_value;
    } in_item_t;

    typedef struct packed {
        logic [3:0]         out_index;
        logic signed [31:0] out_value;
        logic               out_last;
    } out_item_t;

    function automatic logic signed [31:0] atan_q24(input logic [4:0] i);
        logic signed [31:0] v;
        unique case (i)
            5'd0:  v = 32'sd754974720;
            5'd1:  v = 32'sd445687602;
            5'd2:  v = 32'sd235489088;
            5'd3:  v = 32'sd119537938;
            5'd4:  v = 32'sd60000934;
            5'd5:  v = 32'sd30029717;
            5'd6:  v = 32'sd15018523;
            5'd7:  v = 32'sd7509720;
            5'd8:  v = 32'sd3754917;
            5'd9:  v = 32'sd1877466;
            5'd10: v = 32'sd938734;
            5'd11: v = 32'sd469367;
            5'd12: v = 32'sd234684;
            5'd13: v = 32'sd117342;
            5'd14: v = 32'sd58671;
            5'd15: v = 32'sd29335;
            5'd16: v = 32'sd14668;
            5'd17: v = 32'sd7334;
            5'd18: v = 32'sd3667;
            5'd19: v = 32'sd1833;
            5'd20: v = 32'sd917;
            5'd21: v = 32'sd458;
            5'd22: v = 32'sd229;
            5'd23: v = 32'sd115;
            default: v = 32'sd0;
        endcase
        return v;
    endfunction

    function automatic logic signed [31:0] sat32(input logic signed [35:0] v);
        logic signed [31:0] r;
        if (v > 36'sh0_7FFF_FFFF)
            r = 32'sh7FFF_FFFF;
        else if (v < -36'sh0_8000_0000)
            r = 32'sh8000_0000;
        else
            r = v[31:0];
        return r;
    endfunction

    function automatic logic signed [31:0] sat_acc(input logic signed [49:0] v);
        logic signed [31:0] r;
        if (v > 50'sh7FFF_FFFF)
            r = 32'sh7FFF_FFFF;
        else if (v < -50'sh8000_0000)
            r = 32'sh8000_0000;
        else
            r = v[31:0];
        return r;
    endfunction

endpackage
`default_nettype wire

/* design/mat4_transform_accumulator_top.sv */
// ----------------------------------------------------------------------------
// mat4_transform_accumulator_top
// 4x4 Q16.16 transform accumulator: one shared multiplier, CORDIC sequencer.
// ----------------------------------------------------------------------------
// Sequence: identity and stage complete in the idle state; scale, translate and
// multiply run 64 MAC steps, then a copy-back; rotations first add RED_STEPS (8)
// reduction steps, a fold, CORDIC_STEPS steps and a rounding step. Read streams 16 elements.
// Throughput: one request at a time; the input stalls until the sequencer is idle and no stalled output is pending.
// Reset: transform matrix returns to identity; operand matrix is not cleared.
`default_nettype none
`include "mat4_transform_accumulator_top_defines.svh"
module mat4_transform_accumulator_top (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             in_valid,
    output logic                  in_stall,
    input  wire mta_pkg::in_item_t  in_data,
    output logic                  out_valid,
    input  wire logic             out_stall,
    output mta_pkg::out_item_t    out_data
);
    import mta_pkg::*;

    state_t state_reg, state_next;

    logic signed [31:0] mat_reg   [16];
    logic signed [31:0] res_reg   [16];
    logic signed [31:0] opnd_mem  [16];

    logic [3:0]         req_reg;
    logic signed [31:0] ax_reg, ay_reg, az_reg;
    logic signed [33:0] ang_reg;
    logic               neg_reg;
    logic signed [33:0] cx_reg, cy_reg;
    logic [4:0]         step_reg;
    logic signed [31:0] sin_reg, cos_reg;
    logic [5:0]         mac_reg;
    logic signed [49:0] acc_reg;
    logic [3:0]         idx_reg;
    logic               ov_reg;
    out_item_t          od_reg;

    logic accept, done_mac;
    assign in_stall  = (state_reg != ST_IDLE) || (ov_reg && out_stall);
    assign accept    = in_valid && !in_stall;
    assign out_valid = ov_reg;
    assign out_data  = od_reg;

    // Operand of the current MAC step
    logic [1:0] row, col, kk;
    assign row = mac_reg[5:4];
    assign col = mac_reg[3:2];
    assign kk  = mac_reg[1:0];
    logic [3:0] ai, bi;
    assign ai = {row, kk};
    assign bi = {kk, col};

    logic signed [31:0] tval;
    always_comb
    begin
        tval = (bi[1:0] == bi[3:2]) ? ONE_Q : 32'sd0;
        unique case (req_reg)
            REQ_SCALE:
            begin
                if (bi == 4'd0)  tval = ax_reg;
                if (bi == 4'd5)  tval = ay_reg;
                if (bi == 4'd10) tval = az_reg;
            end
            REQ_TRANS:
            begin
                if (bi == 4'd12) tval = ax_reg;
                if (bi == 4'd13) tval = ay_reg;
                if (bi == 4'd14) tval = az_reg;
            end
            REQ_ROT_X:
            begin
                if (bi == 4'd5 || bi == 4'd10) tval = cos_reg;
                if (bi == 4'd6) tval = sin_reg;
                if (bi == 4'd9) tval = sat32(-{{4{sin_reg[31]}}, sin_reg});
            end
            REQ_ROT_Y:
            begin
                if (bi == 4'd0 || bi == 4'd10) tval = cos_reg;
                if (bi == 4'd8) tval = sin_reg;
                if (bi == 4'd2) tval = sat32(-{{4{sin_reg[31]}}, sin_reg});
            end
            REQ_ROT_Z:
            begin
                if (bi == 4'd0 || bi == 4'd5) tval = cos_reg;
                if (bi == 4'd1) tval = sin_reg;
                if (bi == 4'd4) tval = sat32(-{{4{sin_reg[31]}}, sin_reg});
            end
            REQ_MUL: tval = opnd_mem[bi];
            default: tval = tval;
        endcase
    end

    logic signed [63:0] prod;
    logic signed [47:0] prnd;
    logic signed [49:0] acc_sum;
    assign prod    = mat_reg[ai] * tval;
    assign prnd    = 48'((prod + (64'sd1 <<< (FRAC_BITS - 1))) >>> FRAC_BITS);
    assign acc_sum = ((kk == 2'd0) ? 50'sd0 : acc_reg) + 50'(prnd);
    assign done_mac = (mac_reg == 6'd63);

    // CORDIC step
    logic signed [33:0] dx, dy;
    logic [4:0] last_step;
    assign last_step = 5'((CORDIC_STEPS < TABLE_LEN ? CORDIC_STEPS : TABLE_LEN) - 1);
    assign dx = cy_reg >>> step_reg;
    assign dy = cx_reg >>> step_reg;

    // Angle reduction
    logic [4:0]         red_sh;
    logic signed [33:0] red_sub, ang_wrap, ang_fold;
    logic               fold_neg;
    assign red_sh  = 5'(RED_STEPS - 1) - step_reg;
    assign red_sub = FULL_TURN <<< red_sh;

    // Trig rounding
    logic signed [33:0] xf, yf;
    logic signed [35:0] xr, yr;
    assign xf = neg_reg ? -cx_reg : cx_reg;
    assign yf = neg_reg ? -cy_reg : cy_reg;
    assign xr = 36'((xf + (34'sd1 <<< (CORD_FRAC - FRAC_BITS - 1)))
                >>> (CORD_FRAC - FRAC_BITS));
    assign yr = 36'((yf + (34'sd1 <<< (CORD_FRAC - FRAC_BITS - 1)))
                >>> (CORD_FRAC - FRAC_BITS));

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    priority if (in_data.req_type == REQ_SCALE || in_data.req_type == REQ_TRANS
                                 || in_data.req_type == REQ_MUL)
                        state_next = ST_MAC;
                    else if (in_data.req_type == REQ_ROT_X || in_data.req_type == REQ_ROT_Y
                             || in_data.req_type == REQ_ROT_Z)
                        state_next = ST_REDUCE;
                    else if (in_data.req_type == REQ_READ)
                        state_next = ST_READ;
                    else
                        state_next = ST_IDLE;
                end
            end
            ST_REDUCE: if (step_reg == 5'(RED_STEPS - 1)) state_next = ST_FOLD;
            ST_FOLD:   state_next = ST_CORDIC;
            ST_CORDIC: if (step_reg == last_step) state_next = ST_TRIG;
            ST_TRIG:   state_next = ST_MAC;
            ST_MAC:    if (done_mac) state_next = ST_COPY;
            ST_COPY:   state_next = ST_IDLE;
            ST_READ:   if ((!ov_reg || !out_stall) && idx_reg == 4'd15) state_next = ST_IDLE;
            default:   state_next = ST_IDLE;
        endcase
    end

    // Wrap the reduced angle into (-180, 180], then fold into [-90, 90]
    always_comb
    begin
        ang_wrap = ang_reg;
        if (ang_wrap > HALF_TURN)
            ang_wrap = ang_wrap - FULL_TURN;
        ang_fold = ang_wrap;
        fold_neg = 1'b0;
        if (ang_wrap > QUARTER)
        begin
            ang_fold = ang_wrap - HALF_TURN;
            fold_neg = 1'b1;
        end
        else if (ang_wrap < -QUARTER)
        begin
            ang_fold = ang_wrap + HALF_TURN;
            fold_neg = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            ov_reg    <= 1'b0;
            idx_reg   <= 4'd0;
            mac_reg   <= 6'd0;
            step_reg  <= 5'd0;
            for (int i = 0; i < 16; i++)
                mat_reg[i] <= (i % 5 == 0) ? ONE_Q : 32'sd0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == ST_READ && (!ov_reg || !out_stall))
                ov_reg <= 1'b1;
            else if (ov_reg && !out_stall)
                ov_reg <= 1'b0;
            unique case (state_reg)
                ST_IDLE:
                begin
                    mac_reg  <= 6'd0;
                    step_reg <= 5'd0;
                    idx_reg  <= 4'd0;
                    if (accept && in_data.req_type == REQ_IDENTITY)
                        for (int i = 0; i < 16; i++)
                            mat_reg[i] <= (i % 5 == 0) ? ONE_Q : 32'sd0;
                end
                ST_MAC:
                    mac_reg <= mac_reg + 6'd1;
                ST_COPY:
                    for (int i = 0; i < 16; i++)
                        mat_reg[i] <= res_reg[i];
                ST_REDUCE:
                    step_reg <= step_reg + 5'd1;
                ST_FOLD:
                    step_reg <= 5'd0;
                ST_CORDIC:
                    step_reg <= step_reg + 5'd1;
                ST_READ:
                begin
                    if (!ov_reg || !out_stall)
                        idx_reg <= idx_reg + 4'd1;
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == ST_IDLE && accept)
        begin
            req_reg <= in_data.req_type;
            ax_reg  <= in_data.arg_x;
            ay_reg  <= in_data.arg_y;
            az_reg  <= in_data.arg_z;
            // Offset by whole turns so the reduction starts non-negative
            ang_reg <= 34'(in_data.angle) + TURN_OFFSET;
            if (in_data.req_type == REQ_STAGE)
                opnd_mem[in_data.element_index] <= in_data.element_value;
        end
        if (state_reg == ST_READ && (!ov_reg || !out_stall))
        begin
            od_reg.out_index <= idx_reg;
            od_reg.out_value <= mat_reg[idx_reg];
            od_reg.out_last  <= (idx_reg == 4'd15);
        end
        if (state_reg == ST_MAC)
        begin
            acc_reg <= acc_sum;
            if (kk == 2'd3)
                res_reg[{row, col}] <= sat_acc(acc_sum);
        end
        if (state_reg == ST_REDUCE)
        begin
            if (ang_reg >= red_sub)
                ang_reg <= ang_reg - red_sub;
        end
        if (state_reg == ST_FOLD)
        begin
            cx_reg  <= CORD_GAIN;
            cy_reg  <= 34'sd0;
            neg_reg <= fold_neg;
            ang_reg <= ang_fold <<< (ANG_FRAC - FRAC_BITS);
        end
        if (state_reg == ST_CORDIC)
        begin
            if (!ang_reg[33])
            begin
                cx_reg  <= cx_reg - dx;
                cy_reg  <= cy_reg + dy;
                ang_reg <= ang_reg - 34'(atan_q24(step_reg));
            end
            else
            begin
                cx_reg  <= cx_reg + dx;
                cy_reg  <= cy_reg - dy;
                ang_reg <= ang_reg + 34'(atan_q24(step_reg));
            end
        end
        if (state_reg == ST_TRIG)
        begin
            cos_reg <= sat32(xr);
            sin_reg <= sat32(yr);
        end
    end

    `MTA_ASSERT_IMP(a_no_accept_busy, state_reg != ST_IDLE, in_stall)
    `MTA_ASSERT_NXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_data))
    `MTA_ASSERT_IMP(a_mac_only_in_mac, state_reg == ST_COPY, $past(mac_reg) == 6'd63)

endmodule
`default_nettype wire

/* tb/mat4_transform_accumulator_checker.sv */
// ----------------------------------------------------------------------------
// mat4_transform_accumulator_checker
// Watches both channels of the 4x4 transform accumulator, keeps its own copy
// of the transform and operand matrices, predicts every read-out element and
// compares each output transaction field by field against the oldest one.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module mat4_transform_accumulator_checker (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    input  logic               in_stall,
    input  mta_pkg::in_item_t  in_data,
    input  logic               out_valid,
    input  logic               out_stall,
    input  mta_pkg::out_item_t out_data,
    output int                 errors,
    output int                 outstanding
);
    import mta_pkg::*;

    localparam longint ATAN_DEG[24] = '{
        754974720, 445687602, 235489088, 119537938,
        60000934, 30029717, 15018523, 7509720,
        3754917, 1877466, 938734, 469367,
        234684, 117342, 58671, 29335,
        14668, 7334, 3667, 1833,
        917, 458, 229, 115
    };

    int        xform[16];
    int        operand[16];
    out_item_t element_q[$];

    function automatic int clamp32(input longint v);
        if (v > 64'sd2147483647)
            return 32'h7FFF_FFFF;
        if (v < -64'sd2147483648)
            return 32'h8000_0000;
        return int'(v);
    endfunction

    function automatic longint round_down(input longint v, input int s);
        return (v + (longint'(1) <<< (s - 1))) >>> s;
    endfunction

    function automatic void unit_matrix(output int m[16]);
        for (int i = 0; i < 16; i++)
            m[i] = (i % 5 == 0) ? (1 << FRAC_BITS) : 0;
    endfunction

    function automatic void compose(input int t[16]);
        int     r[16];
        longint acc;
        for (int row = 0; row < 4; row++)
            for (int col = 0; col < 4; col++)
            begin
                acc = 0;
                for (int k = 0; k < 4; k++)
                    acc += round_down(longint'(xform[row * 4 + k]) *
                                      longint'(t[k * 4 + col]), FRAC_BITS);
                r[row * 4 + col] = clamp32(acc);
            end
        xform = r;
    endfunction

    function automatic void sin_cos(input logic signed [31:0] ang, output int sn,
                                    output int cs);
        longint turn;
        longint half;
        longint quarter;
        longint a;
        longint x;
        longint y;
        longint dx;
        longint dy;
        bit     flip;
        turn    = longint'(360) <<< ANG_FRAC;
        half    = longint'(180) <<< ANG_FRAC;
        quarter = longint'(90) <<< ANG_FRAC;
        a       = longint'(ang) * (longint'(1) <<< (ANG_FRAC - FRAC_BITS));
        x       = CORD_GAIN;
        y       = 0;
        flip    = 0;
        a = a % turn;
        if (a < 0)
            a += turn;
        if (a > half)
            a -= turn;
        if (a > quarter)
        begin
            a -= half;
            flip = 1;
        end
        else if (a < -quarter)
        begin
            a += half;
            flip = 1;
        end
        for (int i = 0; i < CORDIC_STEPS && i < 24; i++)
        begin
            dx = y >>> i;
            dy = x >>> i;
            if (a >= 0)
            begin
                x -= dx;
                y += dy;
                a -= ATAN_DEG[i];
            end
            else
            begin
                x += dx;
                y -= dy;
                a += ATAN_DEG[i];
            end
        end
        if (flip)
        begin
            x = -x;
            y = -y;
        end
        cs = clamp32(round_down(x, CORD_FRAC - FRAC_BITS));
        sn = clamp32(round_down(y, CORD_FRAC - FRAC_BITS));
    endfunction

    function automatic void apply_request(input in_item_t it);
        int        t[16];
        int        s;
        int        c;
        out_item_t e;
        unit_matrix(t);
        case (req_t'(it.req_type))
            REQ_IDENTITY: unit_matrix(xform);
            REQ_SCALE:
            begin
                t[0]  = it.arg_x;
                t[5]  = it.arg_y;
                t[10] = it.arg_z;
                compose(t);
            end
            REQ_TRANS:
            begin
                t[12] = it.arg_x;
                t[13] = it.arg_y;
                t[14] = it.arg_z;
                compose(t);
            end
            REQ_ROT_X, REQ_ROT_Y, REQ_ROT_Z:
            begin
                sin_cos(it.angle, s, c);
                if (req_t'(it.req_type) == REQ_ROT_X)
                begin
                    t[5] = c; t[6] = s; t[9] = clamp32(-longint'(s)); t[10] = c;
                end
                else if (req_t'(it.req_type) == REQ_ROT_Y)
                begin
                    t[0] = c; t[2] = clamp32(-longint'(s)); t[8] = s; t[10] = c;
                end
                else
                begin
                    t[0] = c; t[1] = s; t[4] = clamp32(-longint'(s)); t[5] = c;
                end
                compose(t);
            end
            REQ_STAGE: operand[it.element_index] = it.element_value;
            REQ_MUL: compose(operand);
            REQ_READ:
                for (int i = 0; i < 16; i++)
                begin
                    e.out_index = 4'(i);
                    e.out_value = xform[i];
                    e.out_last  = (i == 15);
                    element_q.push_back(e);
                end
            default: ;
        endcase
    endfunction

    task automatic report(input string what, input longint got, input longint want);
        $display("%0t mismatch %s: got %0d expected %0d", $realtime, what, got, want);
        errors++;
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        out_item_t e;
        if (!rst_n)
        begin
            unit_matrix(xform);
            operand = '{default: 0};
            element_q.delete();
            errors      = 0;
            outstanding = 0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                if (element_q.size() == 0)
                    report("unexpected transaction, index", out_data.out_index, -1);
                else
                begin
                    e = element_q.pop_front();
                    if (out_data.out_index !== e.out_index)
                        report("out_index", out_data.out_index, e.out_index);
                    if (out_data.out_value !== e.out_value)
                        report("out_value", out_data.out_value, e.out_value);
                    if (out_data.out_last !== e.out_last)
                        report("out_last", out_data.out_last, e.out_last);
                end
            end
            if (in_valid && !in_stall)
                apply_request(in_data);
            outstanding = element_q.size();
        end
    end

endmodule

/* tb/mat4_transform_accumulator_top_tb.sv */
// ----------------------------------------------------------------------------
// mat4_transform_accumulator_top_tb
// Drives directed and random transform requests into the accumulator with
// random idling on both sides and one long output hold-off; the checker
// predicts the read-out matrices and counts mismatches.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module mat4_transform_accumulator_top_tb;
    import mta_pkg::*;

    localparam int CYCLE_LIMIT = 200000;
    localparam int RANDOM_ITEMS = 110;

    logic      clk;
    logic      rst_n;
    logic      in_valid;
    logic      in_stall;
    in_item_t  in_data;
    logic      out_valid;
    logic      out_stall;
    out_item_t out_data;
    int        errors;
    int        outstanding;
    int        cycles;
    bit        calm;
    bit        hold_go;
    bit        held;
    bit [15:0] staged;

    mat4_transform_accumulator_top uut (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .in_data  (in_data),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .out_data (out_data)
    );

    mat4_transform_accumulator_checker checker_i (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .in_data    (in_data),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .out_data   (out_data),
        .errors     (errors),
        .outstanding(outstanding)
    );

    always #4 clk = ~clk;

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    function automatic logic signed [31:0] pick_value();
        case ($urandom_range(0, 5))
            0: return $urandom();
            1: return $urandom_range(0, 1) ? 32'sh7FFF_FFFF : 32'sh8000_0000;
            default: return $signed($urandom_range(0, 8 << 16)) - (4 <<< 16);
        endcase
    endfunction

    function automatic logic signed [31:0] pick_angle();
        case ($urandom_range(0, 3))
            0: return $urandom();
            1: return $signed($urandom_range(0, 8)) * (90 <<< 16) - (360 <<< 16);
            default: return $signed($urandom_range(0, 720 << 16)) - (360 <<< 16);
        endcase
    endfunction

    function automatic in_item_t make_item(input req_t req);
        in_item_t it;
        it.req_type      = req;
        it.arg_x         = pick_value();
        it.arg_y         = pick_value();
        it.arg_z         = pick_value();
        it.angle         = pick_angle();
        it.element_index = 4'($urandom_range(0, 15));
        it.element_value = pick_value();
        return it;
    endfunction

    task automatic send(input in_item_t it);
        in_valid <= 1'b1;
        in_data  <= it;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        if (it.req_type == REQ_STAGE)
            staged[it.element_index] = 1'b1;
        if (!calm && $urandom_range(0, 3) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 5)) @(posedge clk);
        end
    endtask

    task automatic send_req(input req_t req, input logic signed [31:0] x,
                            input logic signed [31:0] y, input logic signed [31:0] z,
                            input logic signed [31:0] ang);
        in_item_t it;
        it       = make_item(req);
        it.arg_x = x;
        it.arg_y = y;
        it.arg_z = z;
        it.angle = ang;
        send(it);
    endtask

    initial
    begin
        out_stall = 1'b0;
        wait (rst_n);
        @(posedge clk);
        forever
        begin
            if (hold_go && !held)
            begin
                out_stall <= 1'b1;
                repeat (300) @(posedge clk);
                held = 1'b1;
            end
            else if (!calm && $urandom_range(0, 3) == 0)
            begin
                out_stall <= 1'b1;
                repeat ($urandom_range(1, 5)) @(posedge clk);
            end
            else
            begin
                out_stall <= 1'b0;
                @(posedge clk);
            end
        end
    end

    initial
    begin
        in_item_t it;
        int       r;
        int       count;
        clk      = 1'b0;
        rst_n    = 1'b0;
        in_valid = 1'b0;
        in_data  = '0;
        cycles   = 0;
        calm     = 1'b0;
        hold_go  = 1'b0;
        held     = 1'b0;
        staged   = '0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_req(REQ_READ, 0, 0, 0, 0);
        send_req(REQ_SCALE, 32'sh7FFF_FFFF, 32'sh8000_0000, 0, 0);
        send_req(REQ_READ, 0, 0, 0, 0);
        send_req(REQ_TRANS, 32'sh7FFF_FFFF, 32'sh8000_0000, -32'sd1, 0);
        send_req(REQ_READ, 0, 0, 0, 0);
        send_req(REQ_IDENTITY, 0, 0, 0, 0);
        send_req(REQ_TRANS, 3 <<< 15, -(2 <<< 16), 1, 0);
        send_req(REQ_SCALE, 2 <<< 16, -(1 <<< 15), 1 <<< 16, 0);
        send_req(REQ_ROT_X, 0, 0, 0, 90 <<< 16);
        send_req(REQ_ROT_Y, 0, 0, 0, -(90 <<< 16));
        send_req(REQ_ROT_Z, 0, 0, 0, 180 <<< 16);
        send_req(REQ_ROT_X, 0, 0, 0, 32'sh8000_0000);
        send_req(REQ_ROT_Y, 0, 0, 0, 32'sh7FFF_FFFF);
        send_req(REQ_ROT_Z, 0, 0, 0, 45 <<< 16);
        send_req(REQ_READ, 0, 0, 0, 0);
        it = make_item(REQ_STAGE);
        it.element_index = 4'd15;
        it.element_value = 32'sh8000_0000;
        send(it);
        it = make_item(REQ_READ);
        it.req_type = 4'd15;
        send(it);
        it.req_type = 4'd9;
        send(it);
        send_req(REQ_READ, 0, 0, 0, 0);

        for (int i = 0; i < 16; i++)
        begin
            it = make_item(REQ_STAGE);
            it.element_index = 4'(i);
            send(it);
        end
        hold_go = 1'b1;
        repeat (3) send_req(REQ_READ, 0, 0, 0, 0);

        count = 0;
        while (count < RANDOM_ITEMS)
        begin
            if (count > RANDOM_ITEMS - 25)
                calm = 1'b1;
            r = $urandom_range(0, 19);
            if (r < 1)
                it = make_item(REQ_IDENTITY);
            else if (r < 4)
                it = make_item(REQ_SCALE);
            else if (r < 6)
                it = make_item(REQ_TRANS);
            else if (r < 9)
                it = make_item(req_t'(REQ_ROT_X + $urandom_range(0, 2)));
            else if (r < 11)
                it = make_item(REQ_STAGE);
            else if (r < 13 && &staged)
                it = make_item(REQ_MUL);
            else if (r < 19)
                it = make_item(REQ_READ);
            else
            begin
                it = make_item(REQ_READ);
                it.req_type = 4'($urandom_range(9, 15));
            end
            send(it);
            if (it.req_type <= REQ_READ)
                count++;
        end
        send_req(REQ_READ, 0, 0, 0, 0);
        in_valid <= 1'b0;

        wait (outstanding == 0);
        repeat (200) @(posedge clk);
        if (errors == 0 && outstanding == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
